// ----- src/rca_pkg.sv -----
`timescale 1ns / 1ps

package rca_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int LAG_W       = 6;
    localparam int CORR_W      = 30;
    localparam int MAX_ROW_DEF = 64;

    localparam logic [CORR_W-1:0]   CORR_MAX = '1;
    localparam logic [SAMPLE_W-1:0] SCALE    = 8'd255;

endpackage

// ----- src/rca_ram.sv -----
`timescale 1ns / 1ps

module rca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/row_circular_autocorrelation.sv -----
`timescale 1ns / 1ps
// Channel  | Handshake                        | Beat
// ---------+----------------------------------+-------------------------------------------
// sample   | start && !busy                   | pixel_sample, row_end
// result   | result_strobe (one cycle, no stall) | lag_index, scaled_correlation,
//          |                                  | row_overflow, last_lag
//
// Samples without row_end take one cycle each; busy stays low while loading.
// The beat with row_end holds busy high until the last lag is emitted: each lag runs W
// reads of two row store copies through one shared 8x8 multiply-accumulate,
// then drains the read, product and accumulate registers and passes one emit state.
// Each result appears in the cycle after its emit state; the final one with busy low.
// Reset clears the sequencer, sample count and overflow flag; the row store is not cleared.

module row_circular_autocorrelation
    import rca_pkg::*;
#(
    parameter int MAX_ROW = MAX_ROW_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [SAMPLE_W-1:0] pixel_sample,
    input  logic                row_end,
    output logic                result_strobe,
    output logic [LAG_W-1:0]    lag_index,
    output logic [CORR_W-1:0]   scaled_correlation,
    output logic                row_overflow,
    output logic                last_lag
);

    localparam int ADDR_W = $clog2(MAX_ROW);
    localparam int CNT_W  = $clog2(MAX_ROW + 1);
    localparam int ACC_W  = PROD_W + CNT_W;
    localparam int WIDE_W = ACC_W + SAMPLE_W;
    localparam int CMP_W  = (WIDE_W > CORR_W) ? WIDE_W : CORR_W;

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_DRAIN, ST_EMIT} state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    w_reg, w_next;
    logic                ovf_reg, ovf_next;
    logic [ADDR_W-1:0]   m_reg, m_next;
    logic [ADDR_W-1:0]   n_reg, n_next;
    logic [ADDR_W-1:0]   j_reg, j_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                rd_last_reg, rd_last_next;
    logic                prod_vld_reg, prod_vld_next;
    logic                prod_last_reg, prod_last_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic                strobe_reg, strobe_next;
    logic [LAG_W-1:0]    lag_reg, lag_next;
    logic [CORR_W-1:0]   corr_reg, corr_next;
    logic                rovf_reg, rovf_next;
    logic                last_reg, last_next;

    logic                we;
    logic                room;
    logic                n_last;
    logic                j_last;
    logic                m_last;
    logic [SAMPLE_W-1:0] rd_a;
    logic [SAMPLE_W-1:0] rd_b;
    logic [WIDE_W-1:0]   wide;
    logic [CORR_W-1:0]   sat;

    rca_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW)) u_ram_a (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (pixel_sample),
        .raddr (n_reg),
        .rdata (rd_a)
    );

    rca_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW)) u_ram_b (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (pixel_sample),
        .raddr (j_reg),
        .rdata (rd_b)
    );

    assign room   = count_reg < CNT_W'(MAX_ROW);
    assign n_last = CNT_W'(n_reg) == (w_reg - CNT_W'(1));
    assign j_last = CNT_W'(j_reg) == (w_reg - CNT_W'(1));
    assign m_last = CNT_W'(m_reg) == (w_reg - CNT_W'(1));

    // (r + 1) * 255 = 256*r - r + 255
    assign wide = {acc_reg, {SAMPLE_W{1'b0}}} - WIDE_W'(acc_reg) + WIDE_W'(SCALE);
    assign sat  = (CMP_W'(wide) > CMP_W'(CORR_MAX)) ? CORR_MAX : CORR_W'(wide);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        w_next         = w_reg;
        ovf_next       = ovf_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        rd_vld_next    = 1'b0;
        rd_last_next   = 1'b0;
        strobe_next    = 1'b0;
        lag_next       = lag_reg;
        corr_next      = corr_reg;
        rovf_next      = rovf_reg;
        last_next      = last_reg;
        we             = 1'b0;

        prod_vld_next  = rd_vld_reg;
        prod_last_next = rd_last_reg;
        prod_next      = PROD_W'(rd_a) * PROD_W'(rd_b);
        acc_next       = prod_vld_reg ? acc_reg + ACC_W'(prod_reg) : acc_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (room)
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (row_end)
                    begin
                        w_next     = room ? count_reg + CNT_W'(1) : count_reg;
                        m_next     = '0;
                        n_next     = '0;
                        j_next     = '0;
                        acc_next   = '0;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                rd_vld_next  = 1'b1;
                rd_last_next = n_last;
                if (n_last)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    n_next = n_reg + ADDR_W'(1);
                    j_next = j_last ? '0 : j_reg + ADDR_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (prod_vld_reg && prod_last_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                lag_next    = LAG_W'(m_reg);
                corr_next   = sat;
                rovf_next   = ovf_reg;
                last_next   = m_last;
                if (m_last)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    m_next     = m_reg + ADDR_W'(1);
                    n_next     = '0;
                    j_next     = m_reg + ADDR_W'(1);
                    acc_next   = '0;
                    state_next = ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            w_reg         <= '0;
            ovf_reg       <= 1'b0;
            m_reg         <= '0;
            n_reg         <= '0;
            j_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            prod_vld_reg  <= 1'b0;
            prod_last_reg <= 1'b0;
            prod_reg      <= '0;
            acc_reg       <= '0;
            strobe_reg    <= 1'b0;
            lag_reg       <= '0;
            corr_reg      <= '0;
            rovf_reg      <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            w_reg         <= w_next;
            ovf_reg       <= ovf_next;
            m_reg         <= m_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            rd_vld_reg    <= rd_vld_next;
            rd_last_reg   <= rd_last_next;
            prod_vld_reg  <= prod_vld_next;
            prod_last_reg <= prod_last_next;
            prod_reg      <= prod_next;
            acc_reg       <= acc_next;
            strobe_reg    <= strobe_next;
            lag_reg       <= lag_next;
            corr_reg      <= corr_next;
            rovf_reg      <= rovf_next;
            last_reg      <= last_next;
        end
    end

    assign busy               = state_reg != ST_IDLE;
    assign result_strobe      = strobe_reg;
    assign lag_index          = lag_reg;
    assign scaled_correlation = corr_reg;
    assign row_overflow       = rovf_reg;
    assign last_lag           = last_reg;

endmodule

// ----- src/rca_chk.sv -----
`timescale 1ns / 1ps

module rca_chk (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic row_end,
    input logic result_strobe,
    input logic last_lag
);

    // beats are spaced by the per-lag latency
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |=> !result_strobe)
        else $error("back-to-back result beats");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last_lag |-> busy)
        else $error("non-final lag while not busy");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && last_lag |-> !busy)
        else $error("still busy after final lag");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && row_end))
        else $error("busy without a row_end beat");

endmodule

bind row_circular_autocorrelation rca_chk u_rca_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .row_end       (row_end),
    .result_strobe (result_strobe),
    .last_lag      (last_lag)
);

// ----- sim/row_circular_autocorrelation_test.sv -----
`timescale 1ns / 1ps

module row_circular_autocorrelation_test;

    import rca_pkg::*;

    localparam int ROW_CAP      = MAX_ROW_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 370;
    localparam int TAIL_CYCLES  = 20;

    typedef enum int
    {
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_FLAT,
        FILL_SPARSE
    } fill_style_t;

    typedef struct packed
    {
        logic [LAG_W-1:0]  lag;
        logic [CORR_W-1:0] corr;
        logic              ovf;
        logic              last;
    } lag_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [SAMPLE_W-1:0] pixel_sample;
    logic                row_end;
    logic                result_strobe;
    logic [LAG_W-1:0]    lag_index;
    logic [CORR_W-1:0]   scaled_correlation;
    logic                row_overflow;
    logic                last_lag;

    logic [SAMPLE_W-1:0] row_copy [ROW_CAP];
    int                  stored_count;
    bit                  dropped_flag;
    lag_result_t         pending_lags [$];
    int                  mismatches;
    int                  cycles;
    int                  burst_left;

    row_circular_autocorrelation #(
        .MAX_ROW(ROW_CAP)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pixel_sample(pixel_sample),
        .row_end(row_end),
        .result_strobe(result_strobe),
        .lag_index(lag_index),
        .scaled_correlation(scaled_correlation),
        .row_overflow(row_overflow),
        .last_lag(last_lag)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic predict_lags(input logic [SAMPLE_W-1:0] s, input logic e);
        longint unsigned acc;
        lag_result_t     r;
        int              j;
        if (stored_count < ROW_CAP)
        begin
            row_copy[stored_count] = s;
            stored_count++;
        end
        else
        begin
            dropped_flag = 1'b1;
        end
        if (e)
        begin
            for (int m = 0; m < stored_count; m++)
            begin
                acc = 0;
                for (int n = 0; n < stored_count; n++)
                begin
                    j = n + m;
                    if (j >= stored_count)
                        j -= stored_count;
                    acc += longint'(row_copy[n]) * longint'(row_copy[j]);
                end
                acc = (acc + 1) * 64'(SCALE);
                if (acc > 64'(CORR_MAX))
                    acc = 64'(CORR_MAX);
                r.lag  = m[LAG_W-1:0];
                r.corr = acc[CORR_W-1:0];
                r.ovf  = dropped_flag;
                r.last = (m + 1 == stored_count);
                pending_lags.insert(pending_lags.size(), r);
            end
            stored_count = 0;
            dropped_flag = 1'b0;
        end
    endtask

    function automatic void check_field(input string name, input longint unsigned exp_v,
                                        input longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        lag_result_t r;
        if (rst_n && result_strobe)
        begin
            if (pending_lags.size() == 0)
            begin
                $error("unexpected result beat: lag %0d", lag_index);
                mismatches++;
            end
            else
            begin
                r = pending_lags.pop_front();
                check_field("lag_index", 64'(r.lag), 64'(lag_index));
                check_field("scaled_correlation", 64'(r.corr), 64'(scaled_correlation));
                check_field("row_overflow", 64'(r.ovf), 64'(row_overflow));
                check_field("last_lag", 64'(r.last), 64'(last_lag));
            end
        end
    end

    // start stays high after a beat; only hold_off and wait_all_results lower it
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic e);
        start        <= 1'b1;
        pixel_sample <= s;
        row_end      <= e;
        do
            @(posedge clk);
        while (busy);
        predict_lags(s, e);
    endtask

    task automatic hold_off(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_all_results;
        start <= 1'b0;
        @(posedge clk);
        while (pending_lags.size() != 0)
            @(posedge clk);
    endtask

    task automatic pace;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
                hold_off($urandom_range(1, 9));
        end
        burst_left--;
    endtask

    task automatic test_single_sample_rows;
        send_sample(8'd0, 1'b1);
        send_sample(8'd255, 1'b1);
        send_sample(8'd1, 1'b1);
        wait_all_results();
    endtask

    task automatic test_short_rows;
        send_sample(8'd0, 1'b0);
        send_sample(8'd255, 1'b1);
        send_sample(8'd255, 1'b0);
        send_sample(8'd255, 1'b0);
        send_sample(8'd0, 1'b1);
        send_sample(8'd128, 1'b0);
        send_sample(8'd1, 1'b0);
        send_sample(8'd254, 1'b0);
        send_sample(8'd127, 1'b1);
        wait_all_results();
    endtask

    // full store of max samples, then a dropped beat and a dropped row_end beat
    task automatic test_full_row_overflow;
        for (int i = 0; i < ROW_CAP; i++)
            send_sample(8'd255, 1'b0);
        send_sample(8'd17, 1'b0);
        send_sample(8'd200, 1'b1);
        wait_all_results();
    endtask

    task automatic test_random_rows;
        int                  sent;
        int                  len;
        fill_style_t         style;
        logic [SAMPLE_W-1:0] flat_value;
        logic [SAMPLE_W-1:0] s;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       len = $urandom_range(60, 68);
                1:       len = $urandom_range(13, 40);
                default: len = $urandom_range(1, 12);
            endcase
            style      = fill_style_t'($urandom_range(0, 3));
            flat_value = SAMPLE_W'($urandom_range(0, 255));
            for (int i = 0; i < len; i++)
            begin
                case (style)
                    FILL_EXTREME: s = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
                    FILL_FLAT:    s = flat_value;
                    FILL_SPARSE:
                        s = ($urandom_range(0, 4) == 0) ? SAMPLE_W'($urandom_range(0, 255)) : 8'd0;
                    default:      s = SAMPLE_W'($urandom_range(0, 255));
                endcase
                pace();
                send_sample(s, i == len - 1);
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
                wait_all_results();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        pixel_sample = '0;
        row_end      = 1'b0;
        stored_count = 0;
        dropped_flag = 1'b0;
        mismatches   = 0;
        cycles       = 0;
        burst_left   = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_sample_rows();
        test_short_rows();
        test_full_row_overflow();
        test_random_rows();

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
